FILE: rtl/stereo_overdrive_filter_delay_unit_defines.svh
// Assertion macros shared by the stereo overdrive filter delay unit.
`ifndef STEREO_OVERDRIVE_FILTER_DELAY_UNIT_DEFINES_SVH
`define STEREO_OVERDRIVE_FILTER_DELAY_UNIT_DEFINES_SVH

// Check a consequence in the same cycle, outside reset.
`define SOFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sofd: check failed");

// Check a consequence in the next cycle, outside reset.
`define SOFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sofd: check failed");

`endif

FILE: rtl/sofd_pkg.sv
// Types, codes and constants shared by the stereo overdrive filter delay unit.
`default_nettype none

package sofd_pkg;

  localparam int DEPTH_DEFAULT = 65536;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DELAY_LIMIT     = 3'd0;
  localparam cfg_idx_t CFG_DRIVE_GAIN      = 3'd1;
  localparam cfg_idx_t CFG_CUTOFF_LEVEL    = 3'd2;
  localparam cfg_idx_t CFG_FEEDBACK_WEIGHT = 3'd3;
  localparam cfg_idx_t CFG_WET_MIX         = 3'd4;

  localparam logic [15:0] RST_DELAY_LIMIT     = 16'd4999;
  localparam logic [15:0] RST_DRIVE_GAIN      = 16'd58982;
  localparam logic [15:0] RST_CUTOFF_LEVEL    = 16'd19661;
  localparam logic [15:0] RST_FEEDBACK_WEIGHT = 16'd13107;
  localparam logic [15:0] RST_WET_MIX         = 16'd19661;

  // Shared multiplier geometry
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic [15:0] delay_limit;
    logic [15:0] drive_gain;
    logic [15:0] cutoff_level;
    logic [15:0] feedback_weight;
    logic [15:0] wet_mix;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ1,
    ST_SQ2,
    ST_DRV,
    ST_CLP,
    ST_MUL,
    ST_ADD,
    ST_ENT1,
    ST_ENT2,
    ST_ENT3,
    ST_OUT1,
    ST_OUT2,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQ1,
    OP_SQ2,
    OP_DRV,
    OP_CLP,
    OP_MUL,
    OP_ADD,
    OP_ENT1,
    OP_ENT2,
    OP_ENT3,
    OP_OUT1,
    OP_OUT2,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ch;
    logic capture;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/stereo_overdrive_filter_delay_unit.sv
// Top level: overdrive, five-stage lowpass and feedback delay on stereo frames.
// A new item is taken only after the last one reaches the output register;
// 22 dependent products share one 25x18 multiplier.
// The next item is taken while a finished result still waits in the output register.
// Reset (synchronous, rst_n low): sequencer idle, filter state, write position and
// fill count cleared, registers to defaults; unwritten delay entries read as zero.
`default_nettype none

`include "stereo_overdrive_filter_delay_unit_defines.svh"

module stereo_overdrive_filter_delay_unit #(
  parameter int DEPTH = sofd_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sofd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sofd_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  sofd_pkg::cfg_idx_t            cfg_index,
  input  logic [sofd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sofd_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;

  // Decode register writes; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELAY_LIMIT:     cfg_nxt.delay_limit     = cfg_data;
        CFG_DRIVE_GAIN:      cfg_nxt.drive_gain      = cfg_data;
        CFG_CUTOFF_LEVEL:    cfg_nxt.cutoff_level    = cfg_data;
        CFG_FEEDBACK_WEIGHT: cfg_nxt.feedback_weight = cfg_data;
        CFG_WET_MIX:         cfg_nxt.wet_mix         = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_limit     <= RST_DELAY_LIMIT;
      cfg_r.drive_gain      <= RST_DRIVE_GAIN;
      cfg_r.cutoff_level    <= RST_CUTOFF_LEVEL;
      cfg_r.feedback_weight <= RST_FEEDBACK_WEIGHT;
      cfg_r.wet_mix         <= RST_WET_MIX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sofd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sofd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // Sequencer and output register checks
  `SOFD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SOFD_ASSERT_NEXT(a_fin_sets_valid, cmd.op == OP_FIN, out_valid)
  `SOFD_ASSERT_SAME(a_valid_from_fin, $rose(out_valid), $past(cmd.op == OP_FIN))
  `SOFD_ASSERT_SAME(a_no_overwrite, cmd.op == OP_FIN, !out_valid || out_ready)

endmodule

`default_nettype wire

FILE: rtl/sofd_ctrl.sv
// Sequencer that steps the shared datapath through one stereo frame.
`default_nettype none

module sofd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sofd_pkg::cmd_t cmd
);
  import sofd_pkg::*;

  localparam logic [2:0] LAST_STAGE = 3'd4;

  state_t     state_r, state_nxt;
  logic       ch_r, ch_nxt;
  logic [2:0] stage_r, stage_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= 1'b0;
      stage_r     <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance the frame sequence and issue datapath commands
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    stage_nxt     = stage_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.ch        = ch_r;
    cmd.capture   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          ch_nxt      = 1'b0;
          state_nxt   = ST_SQ1;
        end
      end
      ST_SQ1: begin
        cmd.op    = OP_SQ1;
        state_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.op    = OP_SQ2;
        state_nxt = ST_DRV;
      end
      ST_DRV: begin
        cmd.op    = OP_DRV;
        state_nxt = ST_CLP;
      end
      ST_CLP: begin
        cmd.op    = OP_CLP;
        stage_nxt = 3'd0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.op = OP_ADD;
        if (stage_r == LAST_STAGE) begin
          state_nxt = ST_ENT1;
        end else begin
          stage_nxt = stage_r + 3'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_ENT1: begin
        cmd.op    = OP_ENT1;
        state_nxt = ST_ENT2;
      end
      ST_ENT2: begin
        cmd.op    = OP_ENT2;
        state_nxt = ST_ENT3;
      end
      ST_ENT3: begin
        cmd.op    = OP_ENT3;
        state_nxt = ST_OUT1;
      end
      ST_OUT1: begin
        cmd.op    = OP_OUT1;
        state_nxt = ST_OUT2;
      end
      ST_OUT2: begin
        cmd.op = OP_OUT2;
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = ST_DRV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait for the output register to drain before loading it
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/sofd_datapath.sv
// Shared multiplier, filter state, delay memory and output register.
`default_nettype none

module sofd_datapath #(
  parameter int DEPTH = sofd_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sofd_pkg::cmd_t      cmd,
  input  sofd_pkg::cfg_t      cfg,
  input  sofd_pkg::in_item_t  in_data,
  output sofd_pkg::out_item_t out_data
);
  import sofd_pkg::*;

  localparam int AW        = $clog2(DEPTH);
  localparam int PW        = (AW < 16) ? AW : 16;
  localparam int MAW       = $clog2(2 * DEPTH);
  localparam int MEM_WORDS = 2 * DEPTH;
  localparam int LIM_CAP   = DEPTH - 1;
  localparam int T_LIMIT   = 1 << 22;

  localparam logic [MAW-1:0]           CH1_BASE = MAW'(DEPTH);
  localparam logic signed [PROD_W-1:0] T_HI     = PROD_W'(T_LIMIT);
  localparam logic signed [PROD_W-1:0] T_LO     = PROD_W'(-T_LIMIT);
  localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO   = PROD_W'(-32768);

  function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
    if (v > SAT_HI) return 16'sh7fff;
    if (v < SAT_LO) return -16'sh8000;
    return v[15:0];
  endfunction

  // Datapath registers
  in_item_t                   in_r;
  logic [15:0]                coef_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [23:0]         s_r;
  logic signed [MUL_A_W-1:0]  diff_r;
  logic signed [15:0]         e_r;
  logic signed [15:0]         f16_r;
  logic signed [15:0]         ent_r;
  logic signed [PROD_W-1:0]   acc_e_r;
  logic signed [PROD_W-1:0]   acc_o_r;
  logic signed [15:0]         y_r [2];
  out_item_t                  out_r;
  logic signed [23:0]         filt_r [2];
  logic [PW-1:0]              pos_r;
  logic [PW:0]                fill_r;
  logic signed [15:0]         rdata_r;
  logic signed [15:0]         delay_mem_r [MEM_WORDS];

  // Combinational values
  logic signed [15:0]         x_sel;
  logic [PW-1:0]              lim_eff;
  logic [PW-1:0]              rd_pos;
  logic [MAW-1:0]             wr_addr;
  logic [MAW-1:0]             rd_addr;
  logic                       e_valid;
  logic                       d_valid;
  logic                       same_slot;
  logic signed [PROD_W-1:0]   drv_shift;
  logic signed [MUL_A_W-1:0]  t_clamp;
  logic signed [PROD_W-1:0]   stage_p;
  logic signed [23:0]         s_add;
  logic signed [MUL_A_W-1:0]  diff_sub;
  logic signed [15:0]         f16_nxt;
  logic signed [PROD_W-1:0]   ent_sum;
  logic signed [15:0]         ent_val;
  logic signed [PROD_W-1:0]   out_sum;
  logic signed [15:0]         y_val;
  logic signed [15:0]         d_sel;
  logic [MUL_B_W-1:0]         fb_comp;
  logic [MUL_B_W-1:0]         wet_comp;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic                       mul_en;
  logic                       mem_we;
  logic                       mem_re;
  logic [MAW-1:0]             mem_rd_addr;

  assign x_sel = cmd.ch ? in_r.right_in : in_r.left_in;

  // Clip the limit to the store and find the slot after the write position
  always_comb begin
    if ({16'b0, cfg.delay_limit} > 32'(LIM_CAP)) begin
      lim_eff = PW'(LIM_CAP);
    end else begin
      lim_eff = PW'(cfg.delay_limit);
    end
    if (pos_r >= lim_eff) begin
      rd_pos = '0;
    end else begin
      rd_pos = pos_r + PW'(1);
    end
  end

  assign wr_addr   = cmd.ch ? (CH1_BASE + MAW'(pos_r)) : MAW'(pos_r);
  assign rd_addr   = cmd.ch ? (CH1_BASE + MAW'(rd_pos)) : MAW'(rd_pos);
  assign e_valid   = {1'b0, pos_r} < fill_r;
  assign d_valid   = {1'b0, rd_pos} < fill_r;
  assign same_slot = (rd_pos == pos_r);

  // Scale down the driven sample and clamp it to plus or minus one
  assign drv_shift = prod_r >>> 7;
  always_comb begin
    if (drv_shift > T_HI) begin
      t_clamp = T_HI[MUL_A_W-1:0];
    end else if (drv_shift < T_LO) begin
      t_clamp = T_LO[MUL_A_W-1:0];
    end else begin
      t_clamp = drv_shift[MUL_A_W-1:0];
    end
  end

  // One lowpass step: move the state and the remaining distance together
  assign stage_p  = prod_r >>> 16;
  assign s_add    = s_r + stage_p[23:0];
  assign diff_sub = diff_r - stage_p[MUL_A_W-1:0];

  assign f16_nxt  = sat16(PROD_W'(s_r >>> 7));
  assign ent_sum  = acc_e_r + prod_r;
  assign ent_val  = ent_sum[31:16];
  assign out_sum  = acc_o_r + prod_r;
  assign y_val    = sat16(out_sum >>> 16);

  // Take the fresh entry when the read lands on the slot just written
  always_comb begin
    if (same_slot) begin
      d_sel = ent_r;
    end else if (d_valid) begin
      d_sel = rdata_r;
    end else begin
      d_sel = '0;
    end
  end

  assign fb_comp  = 18'h10000 - {2'b00, cfg.feedback_weight};
  assign wet_comp = 18'h10000 - {2'b00, cfg.wet_mix};

  // Select multiplier operands
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_SQ1: begin
        mul_a = {9'b0, cfg.cutoff_level};
        mul_b = {2'b0, cfg.cutoff_level};
      end
      OP_SQ2: begin
        mul_a = {9'b0, prod_r[31:16]};
        mul_b = {2'b0, prod_r[31:16]};
      end
      OP_DRV: begin
        mul_a = MUL_A_W'(x_sel);
        mul_b = {2'b0, cfg.drive_gain};
      end
      OP_MUL: begin
        mul_a = diff_r;
        mul_b = {2'b0, coef_r};
      end
      OP_ADD: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = {2'b0, cfg.feedback_weight};
      end
      OP_ENT1: begin
        mul_a = MUL_A_W'(x_sel);
        mul_b = wet_comp;
      end
      OP_ENT2: begin
        mul_a = MUL_A_W'(f16_r);
        mul_b = fb_comp;
      end
      OP_OUT1: begin
        mul_a = MUL_A_W'(d_sel);
        mul_b = {2'b0, cfg.wet_mix};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Drive the single memory port
  assign mem_we      = (cmd.op == OP_ENT3);
  assign mem_re      = (cmd.op == OP_DRV) || (cmd.op == OP_CLP);
  assign mem_rd_addr = (cmd.op == OP_DRV) ? wr_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      delay_mem_r[wr_addr] <= ent_val;
    end
    if (mem_re) begin
      rdata_r <= delay_mem_r[mem_rd_addr];
    end
  end

  // Hold the working values of the current frame
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    unique case (cmd.op)
      OP_DRV: begin
        if (!cmd.ch) begin
          coef_r <= prod_r[31:16];
        end
        s_r <= filt_r[cmd.ch];
      end
      OP_CLP: begin
        diff_r <= t_clamp - MUL_A_W'(s_r);
        e_r    <= e_valid ? rdata_r : '0;
      end
      OP_ADD: begin
        s_r    <= s_add;
        diff_r <= diff_sub;
      end
      OP_ENT1: begin
        acc_e_r <= prod_r;
        f16_r   <= f16_nxt;
      end
      OP_ENT2: acc_o_r <= prod_r;
      OP_ENT3: ent_r   <= ent_val;
      OP_OUT2: y_r[cmd.ch] <= y_val;
      OP_FIN: begin
        out_r.left_out  <= y_r[0];
        out_r.right_out <= y_r[1];
      end
      default: ;
    endcase
  end

  // Store filter state, advance the write position and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r[0] <= '0;
      filt_r[1] <= '0;
      pos_r     <= '0;
      fill_r    <= '0;
    end else begin
      if (cmd.op == OP_ENT1) begin
        filt_r[cmd.ch] <= s_r;
      end
      if (cmd.op == OP_FIN) begin
        pos_r <= rd_pos;
        if ({1'b0, pos_r} >= fill_r) begin
          fill_r <= {1'b0, pos_r} + 1'b1;
        end
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire
